// ===== hdl/tdp_pkg.sv =====
// Shared types and constants for the Thumb data-processing unit.
package tdp_pkg;

  localparam int unsigned XLEN    = 32;
  localparam int unsigned NREGS   = 8;
  localparam int unsigned RIDX_W  = 3;

  // Instruction format tags
  localparam logic [4:0] FMT2_TAG  = 5'b00011;  // bits 15..11
  localparam logic [2:0] FMT1_TAG  = 3'b000;    // bits 15..13
  localparam logic [2:0] FMT3_TAG  = 3'b001;    // bits 15..13
  localparam logic [5:0] FMT4_TAG  = 6'b010000; // bits 15..10

  localparam logic [7:0] SHIFT_32  = 8'd32;

  typedef enum logic [3:0] {
    ALU_AND = 4'h0,
    ALU_EOR = 4'h1,
    ALU_LSL = 4'h2,
    ALU_LSR = 4'h3,
    ALU_ASR = 4'h4,
    ALU_ADC = 4'h5,
    ALU_SBC = 4'h6,
    ALU_ROR = 4'h7,
    ALU_TST = 4'h8,
    ALU_NEG = 4'h9,
    ALU_CMP = 4'hA,
    ALU_CMN = 4'hB,
    ALU_ORR = 4'hC,
    ALU_MUL = 4'hD,
    ALU_BIC = 4'hE,
    ALU_MVN = 4'hF
  } alu_op_e;

  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } shift_e;

  typedef enum logic [1:0] {
    IMM_MOV = 2'd0,
    IMM_CMP = 2'd1,
    IMM_ADD = 2'd2,
    IMM_SUB = 2'd3
  } imm_op_e;

  typedef struct packed {
    logic n;
    logic z;
    logic c;
    logic v;
  } flags_t;

  typedef struct packed {
    logic               action;
    logic [15:0]        instruction;
    logic [RIDX_W-1:0]  load_index;
    logic [XLEN-1:0]    load_value;
  } in_word_t;

  typedef struct packed {
    logic               write_enable;
    logic [RIDX_W-1:0]  dest_index;
    logic [XLEN-1:0]    dest_value;
    flags_t             flags;
    logic               unhandled;
  } result_t;

  typedef struct packed {
    logic               en;
    logic [RIDX_W-1:0]  addr_a;
    logic [RIDX_W-1:0]  addr_b;
  } rf_rd_t;

  typedef struct packed {
    logic               en;
    logic [RIDX_W-1:0]  addr;
    logic [XLEN-1:0]    data;
  } rf_wr_t;

endpackage

// ===== hdl/tdp_if.sv =====
// Valid/ready stream interfaces for the instruction and result channels.
interface tdp_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] instruction;
  logic [2:0]  load_index;
  logic [31:0] load_value;

  modport source (output valid, action, instruction, load_index, load_value, input ready);
  modport sink   (input valid, action, instruction, load_index, load_value, output ready);
endinterface

interface tdp_out_if;
  logic        valid;
  logic        ready;
  logic        write_enable;
  logic [2:0]  dest_index;
  logic [31:0] dest_value;
  logic        flag_n;
  logic        flag_z;
  logic        flag_c;
  logic        flag_v;
  logic        unhandled;

  modport source (output valid, write_enable, dest_index, dest_value, flag_n, flag_z,
                  flag_c, flag_v, unhandled, input ready);
  modport sink   (input valid, write_enable, dest_index, dest_value, flag_n, flag_z,
                  flag_c, flag_v, unhandled, output ready);
endinterface

// ===== hdl/tdp_regfile.sv =====
// Low register file: synchronous memory, two read ports, valid bits and write forwarding.
module tdp_regfile (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tdp_pkg::rf_rd_t             rd_i,
  input  tdp_pkg::rf_wr_t             wr_i,
  output logic [tdp_pkg::XLEN-1:0]    rdata_a_o,
  output logic [tdp_pkg::XLEN-1:0]    rdata_b_o
);

  logic [tdp_pkg::XLEN-1:0]  mem_q [tdp_pkg::NREGS];
  logic [tdp_pkg::XLEN-1:0]  rdat_a_q, rdat_b_q, fwd_data_q;
  logic [tdp_pkg::NREGS-1:0] vld_q, vld_d;
  logic                      rvld_a_q, rvld_b_q, fwd_a_q, fwd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rdat_a_q   <= mem_q[rd_i.addr_a];
      rdat_b_q   <= mem_q[rd_i.addr_b];
      fwd_data_q <= wr_i.data;
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (wr_i.en) begin
      vld_d[wr_i.addr] = 1'b1;
    end
  end

  // A write landing on the same edge as the read is not yet in the read data: forward it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rvld_a_q <= 1'b0;
      rvld_b_q <= 1'b0;
      fwd_a_q  <= 1'b0;
      fwd_b_q  <= 1'b0;
    end else begin
      vld_q <= vld_d;
      if (rd_i.en) begin
        rvld_a_q <= vld_q[rd_i.addr_a];
        rvld_b_q <= vld_q[rd_i.addr_b];
        fwd_a_q  <= wr_i.en && (wr_i.addr == rd_i.addr_a);
        fwd_b_q  <= wr_i.en && (wr_i.addr == rd_i.addr_b);
      end
    end
  end

  assign rdata_a_o = fwd_a_q ? fwd_data_q : (rvld_a_q ? rdat_a_q : '0);
  assign rdata_b_o = fwd_b_q ? fwd_data_q : (rvld_b_q ? rdat_b_q : '0);

endmodule

// ===== hdl/tdp_alu.sv =====
// Execute stage: decode, barrel shifter, adder, multiplier and flag update.
module tdp_alu (
  input  tdp_pkg::in_word_t          word_i,
  input  logic [tdp_pkg::XLEN-1:0]   opa_i,
  input  logic [tdp_pkg::XLEN-1:0]   opb_i,
  input  tdp_pkg::flags_t            flags_i,
  output tdp_pkg::result_t           res_o
);

  // Returns {carry, result}; amount zero keeps value and carry
  function automatic logic [32:0] barrel(input logic [31:0] v, input tdp_pkg::shift_e sh,
                                         input logic [7:0] amt, input logic cin);
    logic [32:0] t;
    logic [63:0] w;
    logic [32:0] r;
    t = '0;
    w = '0;
    r = {cin, v};
    if (amt != 8'd0) begin
      unique case (sh)
        tdp_pkg::SH_LSL: begin
          t = {1'b0, v} << amt[4:0];
          if (amt < tdp_pkg::SHIFT_32) r = {t[32], t[31:0]};
          else if (amt == tdp_pkg::SHIFT_32) r = {v[0], 32'd0};
          else r = '0;
        end
        tdp_pkg::SH_LSR: begin
          t = {v, 1'b0} >> amt[4:0];
          if (amt < tdp_pkg::SHIFT_32) r = {t[0], t[32:1]};
          else if (amt == tdp_pkg::SHIFT_32) r = {v[31], 32'd0};
          else r = '0;
        end
        tdp_pkg::SH_ASR: begin
          t = 33'($signed({v, 1'b0}) >>> amt[4:0]);
          if (amt < tdp_pkg::SHIFT_32) r = {t[0], t[32:1]};
          else r = {v[31], {32{v[31]}}};
        end
        tdp_pkg::SH_ROR: begin
          w = {v, v} >> amt[4:0];
          r = {w[31], w[31:0]};
        end
        default: r = {cin, v};
      endcase
    end
    return r;
  endfunction

  logic                 is_f1, is_f2, is_f3, is_f4;
  tdp_pkg::alu_op_e     op4;
  tdp_pkg::imm_op_e     op3;
  logic [31:0]          imm8, b2;
  logic [31:0]          add_a, add_b;
  logic                 add_ci;
  logic [32:0]          sum;
  logic                 sum_v;
  logic [31:0]          sh_v;
  tdp_pkg::shift_e      sh_t;
  logic [7:0]           sh_amt;
  logic [32:0]          sh_out;
  logic [31:0]          prod;
  logic [31:0]          res;
  tdp_pkg::flags_t      fl;
  logic                 we;
  logic [2:0]           di;

  assign is_f2 = !word_i.action && (word_i.instruction[15:11] == tdp_pkg::FMT2_TAG);
  assign is_f1 = !word_i.action && !is_f2 && (word_i.instruction[15:13] == tdp_pkg::FMT1_TAG);
  assign is_f3 = !word_i.action && (word_i.instruction[15:13] == tdp_pkg::FMT3_TAG);
  assign is_f4 = !word_i.action && (word_i.instruction[15:10] == tdp_pkg::FMT4_TAG);
  assign op4   = tdp_pkg::alu_op_e'(word_i.instruction[9:6]);
  assign op3   = tdp_pkg::imm_op_e'(word_i.instruction[12:11]);
  assign imm8  = {24'd0, word_i.instruction[7:0]};
  assign b2    = word_i.instruction[10] ? {29'd0, word_i.instruction[8:6]} : opb_i;

  // Adder operand selection
  always_comb begin
    add_a  = opa_i;
    add_b  = ~opb_i;
    add_ci = 1'b1;
    if (is_f2) begin
      add_b  = word_i.instruction[9] ? ~b2 : b2;
      add_ci = word_i.instruction[9];
    end else if (is_f3) begin
      add_b  = (op3 == tdp_pkg::IMM_ADD) ? imm8 : ~imm8;
      add_ci = (op3 != tdp_pkg::IMM_ADD);
    end else begin
      unique case (op4)
        tdp_pkg::ALU_ADC: begin add_b = opb_i;  add_ci = flags_i.c; end
        tdp_pkg::ALU_SBC: begin add_ci = flags_i.c; end
        tdp_pkg::ALU_NEG: begin add_a = '0; end
        tdp_pkg::ALU_CMN: begin add_b = opb_i;  add_ci = 1'b0; end
        default: ;
      endcase
    end
  end

  assign sum   = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_ci};
  assign sum_v = (add_a[31] ~^ add_b[31]) & (add_a[31] ^ sum[31]);

  // Shifter operand selection
  always_comb begin
    sh_v   = opa_i;
    sh_t   = tdp_pkg::shift_e'(word_i.instruction[12:11]);
    sh_amt = {3'd0, word_i.instruction[10:6]};
    if (is_f1) begin
      if (word_i.instruction[10:6] == 5'd0 && sh_t != tdp_pkg::SH_LSL) begin
        sh_amt = tdp_pkg::SHIFT_32;
      end
    end else begin
      sh_amt = opb_i[7:0];
      unique case (op4)
        tdp_pkg::ALU_LSR: sh_t = tdp_pkg::SH_LSR;
        tdp_pkg::ALU_ASR: sh_t = tdp_pkg::SH_ASR;
        tdp_pkg::ALU_ROR: sh_t = tdp_pkg::SH_ROR;
        default:          sh_t = tdp_pkg::SH_LSL;
      endcase
    end
  end

  assign sh_out = barrel(sh_v, sh_t, sh_amt, flags_i.c);
  assign prod   = opa_i * opb_i;

  always_comb begin
    res = sum[31:0];
    fl  = flags_i;
    we  = 1'b0;
    di  = word_i.instruction[2:0];
    if (word_i.action) begin
      we  = 1'b1;
      di  = word_i.load_index;
      res = word_i.load_value;
    end else if (is_f2) begin
      we   = 1'b1;
      fl.c = sum[32];
      fl.v = sum_v;
    end else if (is_f1) begin
      we   = 1'b1;
      res  = sh_out[31:0];
      fl.c = sh_out[32];
    end else if (is_f3) begin
      di = word_i.instruction[10:8];
      we = (op3 != tdp_pkg::IMM_CMP);
      if (op3 == tdp_pkg::IMM_MOV) begin
        res = imm8;
      end else begin
        fl.c = sum[32];
        fl.v = sum_v;
      end
    end else if (is_f4) begin
      we = 1'b1;
      unique case (op4)
        tdp_pkg::ALU_AND: res = opa_i & opb_i;
        tdp_pkg::ALU_EOR: res = opa_i ^ opb_i;
        tdp_pkg::ALU_TST: begin res = opa_i & opb_i; we = 1'b0; end
        tdp_pkg::ALU_ORR: res = opa_i | opb_i;
        tdp_pkg::ALU_MUL: res = prod;
        tdp_pkg::ALU_BIC: res = opa_i & ~opb_i;
        tdp_pkg::ALU_MVN: res = ~opb_i;
        tdp_pkg::ALU_LSL, tdp_pkg::ALU_LSR, tdp_pkg::ALU_ASR, tdp_pkg::ALU_ROR: begin
          res  = sh_out[31:0];
          fl.c = sh_out[32];
        end
        tdp_pkg::ALU_ADC, tdp_pkg::ALU_SBC, tdp_pkg::ALU_NEG: begin
          fl.c = sum[32];
          fl.v = sum_v;
        end
        tdp_pkg::ALU_CMP, tdp_pkg::ALU_CMN: begin
          we   = 1'b0;
          fl.c = sum[32];
          fl.v = sum_v;
        end
        default: ;
      endcase
    end
    if (!word_i.action && (is_f1 || is_f2 || is_f3 || is_f4)) begin
      fl.n = res[31];
      fl.z = (res == 32'd0);
    end
  end

  assign res_o.write_enable = we;
  assign res_o.dest_index   = we ? di : 3'd0;
  assign res_o.dest_value   = we ? res : 32'd0;
  assign res_o.flags        = fl;
  assign res_o.unhandled    = !word_i.action && !(is_f1 || is_f2 || is_f3 || is_f4);

endmodule

// ===== hdl/thumb_data_processing_unit.sv =====
// Top level of the Thumb data-processing unit: read, execute, write back, output register.
//
//  channel  dir  width  word contents
//  in_i     in   52     action, instruction, load_index, load_value
//  out_o    out  41     write_enable, dest_index, dest_value, flag_n/z/c/v, unhandled
//
// One word per cycle sustained while out_o is ready; words pass through s1_q and out_res_q.
// Read stage: register file read (synchronous memory, two read ports).
// Execute stage: execute and write back; a same-edge write is forwarded to that read.
// Reset leaves all registers at zero via valid bits and clears the flags; no clearing pass.
// A stall on out_o holds the execute stage, and in_i stalls once that stage is full.
module thumb_data_processing_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  tdp_in_if.sink          in_i,
  tdp_out_if.source       out_o
);

  tdp_pkg::in_word_t             s1_q;
  logic                          s1_valid_q, s1_valid_d;
  logic                          out_valid_q, out_valid_d;
  tdp_pkg::result_t              out_res_q;
  tdp_pkg::result_t              alu_res;
  tdp_pkg::flags_t               flags_q;
  tdp_pkg::rf_rd_t               rf_rd;
  tdp_pkg::rf_wr_t               rf_wr;
  logic [tdp_pkg::XLEN-1:0]      opa, opb;
  logic                          in_fire, exec_fire;

  assign exec_fire = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || exec_fire;
  assign in_fire   = in_i.valid && in_i.ready;

  // Read port A: Rd for formats 3 and 4, else bits 5..3; port B: Rm for format 2, else bits 5..3
  always_comb begin
    rf_rd.en     = in_fire;
    rf_rd.addr_a = in_i.instruction[5:3];
    rf_rd.addr_b = in_i.instruction[5:3];
    if (in_i.instruction[15:13] == tdp_pkg::FMT3_TAG) begin
      rf_rd.addr_a = in_i.instruction[10:8];
    end else if (in_i.instruction[15:10] == tdp_pkg::FMT4_TAG) begin
      rf_rd.addr_a = in_i.instruction[2:0];
    end
    if (in_i.instruction[15:11] == tdp_pkg::FMT2_TAG) begin
      rf_rd.addr_b = in_i.instruction[8:6];
    end
  end

  tdp_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_i      (rf_rd),
    .wr_i      (rf_wr),
    .rdata_a_o (opa),
    .rdata_b_o (opb)
  );

  tdp_alu u_alu (
    .word_i  (s1_q),
    .opa_i   (opa),
    .opb_i   (opb),
    .flags_i (flags_q),
    .res_o   (alu_res)
  );

  assign rf_wr.en   = exec_fire && alu_res.write_enable;
  assign rf_wr.addr = alu_res.dest_index;
  assign rf_wr.data = alu_res.dest_value;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) s1_valid_d = 1'b1;
    else if (exec_fire) s1_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (exec_fire) out_valid_d = 1'b1;
    else if (out_o.ready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flags_q     <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (exec_fire) flags_q <= alu_res.flags;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q.action      <= in_i.action;
      s1_q.instruction <= in_i.instruction;
      s1_q.load_index  <= in_i.load_index;
      s1_q.load_value  <= in_i.load_value;
    end
    if (exec_fire) out_res_q <= alu_res;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.write_enable = out_res_q.write_enable;
  assign out_o.dest_index   = out_res_q.dest_index;
  assign out_o.dest_value   = out_res_q.dest_value;
  assign out_o.flag_n       = out_res_q.flags.n;
  assign out_o.flag_z       = out_res_q.flags.z;
  assign out_o.flag_c       = out_res_q.flags.c;
  assign out_o.flag_v       = out_res_q.flags.v;
  assign out_o.unhandled    = out_res_q.unhandled;

`ifndef NO_ASSERTIONS
  // Loads and unhandled words leave the flags alone
  a_flags_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire && (s1_q.action || alu_res.unhandled) |=> flags_q == $past(flags_q))
    else $error("flags changed on load or unhandled word");

  // The output register shows the flags state after the executed word
  a_out_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire |=> out_valid_q && out_res_q.flags == flags_q)
    else $error("output flags differ from flag register");

  // A held execute stage keeps its word
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !exec_fire |=> s1_valid_q && $stable(s1_q))
    else $error("execute stage lost a stalled word");

  // Only executing words write the register file
  a_wr_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_wr.en |-> s1_valid_q && !alu_res.unhandled)
    else $error("register write without an executing word");
`endif

endmodule
